/* rtl/core/rfd_pkg.sv */
package rfd_pkg;

    localparam int PULSE_COUNT_DEF = 100;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [15:0] PREAMBLE_MIN_RST  = 16'd2400;
    localparam logic [15:0] MID_THRESHOLD_RST = 16'd500;
    localparam logic [15:0] LONG_MAX_RST      = 16'd800;

    localparam logic [6:0] IDX_MAX        = 7'h7F;
    localparam logic [6:0] FIRST_DATA_IDX = 7'd2;
    localparam logic [6:0] LAST_DATA_IDX  = 7'd95;
    localparam logic [5:0] ID_BITS        = 6'd24;

    localparam logic [6:0]  TAIL_TEMP   = 7'h41;
    localparam logic [6:0]  TAIL_HUM    = 7'h42;
    localparam logic [22:0] SWITCH_MASK = 23'h7FFFBF;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_WRONG_COUNT = 3'd1,
        ST_PREAMBLE    = 3'd2,
        ST_LONG        = 3'd3,
        ST_PAIR        = 3'd4,
        ST_UNKNOWN     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        KIND_TEMP   = 2'd0,
        KIND_HUM    = 2'd1,
        KIND_SWITCH = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_PREAMBLE_MIN  = 2'd0,
        CFG_MID_THRESHOLD = 2'd1,
        CFG_LONG_MAX      = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] preamble_min;
        logic [15:0] mid_threshold;
        logic [15:0] long_max;
    } t_cfg;

    typedef struct packed {
        logic    bit_valid;
        logic    bit_value;
        t_status err;
        logic    last;
        logic    count_ok;
    } t_token;

    typedef struct packed {
        t_status     status;
        t_kind       frame_kind;
        logic [23:0] device_id;
        logic [8:0]  temperature_tenths;
        logic [7:0]  humidity;
        logic [1:0]  switch_letter;
        logic [2:0]  button;
        logic        switch_on;
        logic        group_command;
    } t_result;

endpackage

/* rtl/core/rfd_pulse_if.sv */
interface rfd_pulse_if import rfd_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [15:0] pulse_width;
    logic        last_pulse;

    modport source(output valid, output pulse_width, output last_pulse, input ready);
    modport sink(input valid, input pulse_width, input last_pulse, output ready);
endinterface

/* rtl/core/rfd_result_if.sv */
interface rfd_result_if import rfd_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [1:0]  frame_kind;
    logic [23:0] device_id;
    logic [8:0]  temperature_tenths;
    logic [7:0]  humidity;
    logic [1:0]  switch_letter;
    logic [2:0]  button;
    logic        switch_on;
    logic        group_command;

    modport source(output valid, output status, output frame_kind, output device_id,
                   output temperature_tenths, output humidity, output switch_letter,
                   output button, output switch_on, output group_command, input ready);
    modport sink(input valid, input status, input frame_kind, input device_id,
                 input temperature_tenths, input humidity, input switch_letter,
                 input button, input switch_on, input group_command, output ready);
endinterface

/* rtl/core/rf_pulse_frame_decoder_top.sv */
// Accepts one pulse per cycle; a four-entry token queue between the pulse classifier
// and the frame assembler lets the input keep flowing while a result waits to be taken.
// A result becomes valid when the frame assembler pops the token of the last pulse from
// the queue, once the tokens ahead of it are gone and the output is free.
// Throughput is one pulse per cycle, limited only by the output stage holding one result.
// Synchronous active-low reset clears the capture state, the queue and the output valid,
// and restores the threshold registers to their default values.
module rf_pulse_frame_decoder_top import rfd_pkg::*; #(
    parameter int PULSE_COUNT = PULSE_COUNT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    rfd_pulse_if.sink    i_pulse,
    rfd_result_if.source o_result
);

    t_cfg   r_cfg;
    logic   tok_valid;
    logic   tok_ready;
    t_token tok;
    logic   q_valid;
    logic   q_pop;
    t_token q_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preamble_min  <= PREAMBLE_MIN_RST;
            r_cfg.mid_threshold <= MID_THRESHOLD_RST;
            r_cfg.long_max      <= LONG_MAX_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PREAMBLE_MIN:  r_cfg.preamble_min  <= i_cfg_data;
                CFG_MID_THRESHOLD: r_cfg.mid_threshold <= i_cfg_data;
                CFG_LONG_MAX:      r_cfg.long_max      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rfd_front #(
        .PULSE_COUNT(PULSE_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pulse     (i_pulse),
        .i_tok_ready (tok_ready),
        .o_tok_valid (tok_valid),
        .o_tok       (tok)
    );

    rfd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (tok_valid),
        .o_push_ready (tok_ready),
        .i_push_data  (tok),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_data   (q_tok)
    );

    rfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_tok       (q_tok),
        .o_tok_pop   (q_pop),
        .o_result    (o_result)
    );

    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.status != ST_OK |->
            o_result.device_id == '0 && o_result.frame_kind == KIND_TEMP &&
            o_result.button == '0 && o_result.temperature_tenths == '0)
        else $error("error result carries nonzero fields");

    a_switch_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.status == ST_OK && o_result.frame_kind == KIND_SWITCH |->
            o_result.switch_on == 1'b0 && o_result.device_id[23:19] == '0 &&
            o_result.button != '0)
        else $error("switch frame fields out of range");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> o_result.temperature_tenths <= 9'd325)
        else $error("temperature out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid right after reset");

endmodule

/* rtl/core/rfd_front.sv */
module rfd_front import rfd_pkg::*; #(
    parameter int PULSE_COUNT = PULSE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    rfd_pulse_if.sink   i_pulse,
    input  logic        i_tok_ready,
    output logic        o_tok_valid,
    output t_token      o_tok
);

    logic [6:0]  r_idx;
    logic [6:0]  n_idx;
    logic [15:0] r_held;
    logic [6:0]  idx_inc;
    logic        accept;
    logic        in_data;
    logic [15:0] w;

    assign w               = i_pulse.pulse_width;
    assign i_pulse.ready   = i_tok_ready;
    assign o_tok_valid     = i_pulse.valid;
    assign accept          = i_pulse.valid && i_tok_ready;
    assign idx_inc         = (r_idx == IDX_MAX) ? r_idx : r_idx + 7'd1;
    assign in_data         = (idx_inc >= FIRST_DATA_IDX) && (idx_inc <= LAST_DATA_IDX);
    assign n_idx           = i_pulse.last_pulse ? 7'd0 : idx_inc;

    always_comb begin
        o_tok.bit_valid = 1'b0;
        o_tok.bit_value = 1'b0;
        o_tok.err       = ST_OK;
        o_tok.last      = i_pulse.last_pulse;
        o_tok.count_ok  = (idx_inc == 7'(PULSE_COUNT));
        if (idx_inc == 7'd1) begin
            if (w < i_cfg.preamble_min) begin
                o_tok.err = ST_PREAMBLE;
            end
        end else if (in_data && idx_inc[0]) begin
            o_tok.bit_valid = 1'b1;
            if (r_held > i_cfg.mid_threshold) begin
                o_tok.bit_value = 1'b1;
                if (r_held > i_cfg.long_max) begin
                    o_tok.err = ST_LONG;
                end else if (w > i_cfg.mid_threshold) begin
                    o_tok.err = ST_PAIR;
                end
            end else if (w < i_cfg.mid_threshold) begin
                o_tok.err = ST_PAIR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 7'd0;
        end else if (accept) begin
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && in_data && !idx_inc[0]) begin
            r_held <= w;
        end
    end

endmodule

/* rtl/core/rfd_queue.sv */
module rfd_queue import rfd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_token i_push_data,
    output logic   o_pop_valid,
    input  logic   i_pop,
    output t_token o_pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_token             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_data   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/core/rfd_back.sv */
module rfd_back import rfd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_tok_valid,
    input  t_token       i_tok,
    output logic         o_tok_pop,
    rfd_result_if.source o_result
);

    logic [23:0] r_id;
    logic [22:0] r_tail;
    logic [5:0]  r_bits;
    t_status     r_err;
    logic [23:0] n_id;
    logic [22:0] n_tail;
    logic [5:0]  n_bits;
    t_status     n_err;
    logic        r_out_valid;
    t_result     r_out;
    t_result     res;
    logic        out_free;
    logic        pop;

    assign out_free  = !r_out_valid || o_result.ready;
    assign pop       = i_tok_valid && (!i_tok.last || out_free);
    assign o_tok_pop = pop;

    always_comb begin
        n_id   = r_id;
        n_tail = r_tail;
        n_bits = r_bits;
        n_err  = r_err;
        if (i_tok.bit_valid) begin
            if (r_bits < ID_BITS) begin
                n_id = {r_id[22:0], i_tok.bit_value};
            end else begin
                n_tail = {r_tail[21:0], i_tok.bit_value};
            end
            n_bits = r_bits + 6'd1;
        end
        if (r_err == ST_OK) begin
            n_err = i_tok.err;
        end
    end

    always_comb begin
        res = '0;
        if (!i_tok.count_ok) begin
            res.status = ST_WRONG_COUNT;
        end else if (n_err != ST_OK) begin
            res.status = n_err;
        end else if (n_tail[6:0] == TAIL_TEMP) begin
            res.frame_kind         = KIND_TEMP;
            res.device_id          = n_id;
            res.temperature_tenths = 9'(n_tail[19:15]) * 9'd10 + 9'(n_tail[10:7]);
        end else if (n_tail[6:0] == TAIL_HUM) begin
            res.frame_kind = KIND_HUM;
            res.device_id  = n_id;
            res.humidity   = n_tail[22:15];
        end else if ((n_tail & SWITCH_MASK) == '0) begin
            res.frame_kind    = KIND_SWITCH;
            res.device_id     = {5'd0, n_id[23:5]};
            res.switch_letter = {n_id[3], n_id[4]};
            res.button        = {1'b0, n_id[1:0]} + 3'd1;
            res.switch_on     = n_tail[7];
            res.group_command = n_tail[6];
        end else begin
            res.status = ST_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id   <= '0;
            r_tail <= '0;
            r_bits <= '0;
            r_err  <= ST_OK;
        end else if (pop) begin
            if (i_tok.last) begin
                r_id   <= '0;
                r_tail <= '0;
                r_bits <= '0;
                r_err  <= ST_OK;
            end else begin
                r_id   <= n_id;
                r_tail <= n_tail;
                r_bits <= n_bits;
                r_err  <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop && i_tok.last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_tok.last) begin
            r_out <= res;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.status             = r_out.status;
    assign o_result.frame_kind         = r_out.frame_kind;
    assign o_result.device_id          = r_out.device_id;
    assign o_result.temperature_tenths = r_out.temperature_tenths;
    assign o_result.humidity           = r_out.humidity;
    assign o_result.switch_letter      = r_out.switch_letter;
    assign o_result.button             = r_out.button;
    assign o_result.switch_on          = r_out.switch_on;
    assign o_result.group_command      = r_out.group_command;

endmodule
